FILE: sv/chas_pkg.sv
// Package for the chained hash address set: sizes, codes, payload and control types.
package chas_pkg;

  localparam int BUCKETS = 1024;
  localparam int SLOTS   = 1024;
  localparam int BW      = $clog2(BUCKETS);
  localparam int SW      = $clog2(SLOTS);
  localparam int CLR_N   = (BUCKETS > SLOTS) ? BUCKETS : SLOTS;
  localparam int CW      = $clog2(CLR_N);
  localparam int KEY_W   = 38;
  localparam int SLOT_W  = 10;

  localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key_addr;
    logic [5:0]  key_prefix;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    logic          vld;
    logic [SW-1:0] idx;
  } link_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_BKT, S_HRD, S_HCHK, S_WALK, S_SCAN_RD, S_SCAN_CK,
    S_INS1, S_INS2, S_DEL1, S_DEL2, S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_HASH, OP_BKT, OP_HEAD_RD, OP_HEAD_CHK, OP_WALK,
    OP_SCAN_RD, OP_SCAN_CK, OP_INS_SLOT, OP_INS_LINK, OP_DEL_LINK, OP_DEL_SLOT,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    RES_HIT, RES_PRESENT, RES_MISS, RES_FULL, RES_NEW
  } res_t;

  typedef struct packed {
    dp_op_t op;
    res_t   res;
  } ctl_cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic       link_vld;
    logic       key_match;
    logic       used;
    logic       scan_last;
    logic       out_free;
    logic [1:0] cmd;
  } dp_status_t;

endpackage

FILE: sv/chas_datapath.sv
// Datapath: bucket and slot memories, hash, chain walk, free scan and result register.
module chas_datapath import chas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ctl_cmd_t   ctl,
  output dp_status_t sts,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  logic [BW-1:0]    bucket_head_vld_unused;
  link_t            bucket_head [BUCKETS];
  logic [KEY_W-1:0] slot_key    [SLOTS];
  link_t            slot_next   [SLOTS];
  logic             slot_used   [SLOTS];

  logic [1:0]       cmd;
  logic [KEY_W-1:0] key;
  logic [BW-1:0]    p0, p1, p2;
  logic [BW-1:0]    bucket;
  link_t            head_rd, next_rd, link, prev, nxt, fp;
  logic [KEY_W-1:0] key_rd;
  logic             used_rd;
  logic [SW-1:0]    at, cur;
  logic [SW:0]      cnt;
  logic [CW-1:0]    clr;
  logic [SW-1:0]    rd_idx;
  logic [63:0]      prod0;
  logic [31+BW:0]   prod1;
  logic [5+32:0]    prod2;
  logic [SW+SLOT_W-1:0] at_ext;

  assign bucket_head_vld_unused = '0;

  assign rd_idx = (ctl.op == OP_HEAD_CHK) ? head_rd.idx : next_rd.idx;
  assign prod0  = {32'b0, key[31:0]} * {32'b0, HASH_MUL[31:0]};
  assign prod1  = key[31:0] * HASH_MUL[32 +: BW];
  assign prod2  = key[37:32] * HASH_MUL[31:0];
  assign at_ext = {{SLOT_W{1'b0}}, at};

  assign sts.clear_last = (clr == CW'(CLR_N - 1));
  assign sts.link_vld   = (ctl.op == OP_HEAD_CHK) ? head_rd.vld : next_rd.vld;
  assign sts.key_match  = (key_rd == key);
  assign sts.used       = used_rd;
  assign sts.scan_last  = (cnt == (SW+1)'(SLOTS - 1));
  assign sts.out_free   = !out_valid;
  assign sts.cmd        = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (ctl.op == OP_CLEAR) begin
      clr <= clr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    head_rd <= bucket_head[bucket];
    case (ctl.op)
      OP_CLEAR: begin
        if ({1'b0, clr} < (CW+1)'(BUCKETS)) begin
          bucket_head[clr[BW-1:0]] <= '0;
        end
      end
      OP_INS_LINK: begin
        if (!prev.vld) begin
          bucket_head[bucket] <= '{vld: 1'b1, idx: at};
        end
      end
      OP_DEL_LINK: begin
        if (!prev.vld) begin
          bucket_head[bucket] <= nxt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    next_rd <= slot_next[rd_idx];
    case (ctl.op)
      OP_CLEAR: begin
        if ({1'b0, clr} < (CW+1)'(SLOTS)) begin
          slot_next[clr[SW-1:0]] <= '0;
        end
      end
      OP_INS_SLOT: slot_next[at] <= '0;
      OP_INS_LINK: begin
        if (prev.vld) begin
          slot_next[prev.idx] <= '{vld: 1'b1, idx: at};
        end
      end
      OP_DEL_LINK: begin
        if (prev.vld) begin
          slot_next[prev.idx] <= nxt;
        end
      end
      OP_DEL_SLOT: slot_next[at] <= '0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_rd <= slot_key[rd_idx];
    if (ctl.op == OP_INS_SLOT) begin
      slot_key[at] <= key;
    end
  end

  always_ff @(posedge clk) begin
    used_rd <= slot_used[cur];
    case (ctl.op)
      OP_CLEAR: begin
        if ({1'b0, clr} < (CW+1)'(SLOTS)) begin
          slot_used[clr[SW-1:0]] <= 1'b0;
        end
      end
      OP_INS_SLOT: slot_used[at] <= 1'b1;
      OP_DEL_LINK: slot_used[at] <= 1'b0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp <= '0;
    end else if (ctl.op == OP_INS_LINK || ctl.op == OP_DEL_LINK) begin
      fp <= '{vld: 1'b1, idx: at};
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd <= in_data.cmd;
        key <= {in_data.key_prefix, in_data.key_addr};
        cur <= fp.vld ? fp.idx : '0;
        cnt <= '0;
      end
      OP_HASH: begin
        p0 <= prod0[32 +: BW];
        p1 <= prod1[BW-1:0];
        p2 <= prod2[BW-1:0];
      end
      OP_BKT: bucket <= p0 + p1 + p2 + bucket_head_vld_unused;
      OP_HEAD_CHK: begin
        link <= head_rd;
        prev <= '0;
      end
      OP_WALK: begin
        if (key_rd == key) begin
          at  <= link.idx;
          nxt <= next_rd;
        end else begin
          prev <= link;
          link <= next_rd;
        end
      end
      OP_SCAN_CK: begin
        if (!used_rd) begin
          at <= cur;
        end else begin
          cur <= ({1'b0, cur} == (SW+1)'(SLOTS - 1)) ? '0 : cur + SW'(1);
          cnt <= cnt + (SW+1)'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_FINISH) begin
      case (ctl.res)
        RES_HIT:     out_data <= '{found: 1'b1, slot: at_ext[SLOT_W-1:0], status: ST_DONE};
        RES_PRESENT: out_data <= '{found: 1'b1, slot: at_ext[SLOT_W-1:0], status: ST_PRESENT};
        RES_FULL:    out_data <= '{found: 1'b0, slot: '0, status: ST_FULL};
        RES_NEW:     out_data <= '{found: 1'b0, slot: at_ext[SLOT_W-1:0], status: ST_DONE};
        default:     out_data <= '{found: 1'b0, slot: '0, status: ST_NOT_FOUND};
      endcase
    end
  end

endmodule

FILE: sv/chas_controller.sv
// Controller: sequences clearing, hashing, chain walk, free scan and table updates.
module chas_controller import chas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctl_cmd_t   ctl
);

  state_t state, state_next;
  res_t   res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      res   <= RES_MISS;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    case (state)
      S_CLEAR:   if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:    if (in_valid) state_next = S_HASH;
      S_HASH:    state_next = S_BKT;
      S_BKT:     state_next = S_HRD;
      S_HRD:     state_next = S_HCHK;
      S_HCHK, S_WALK: begin
        if (state == S_WALK && sts.key_match) begin
          case (sts.cmd)
            CMD_INSERT: begin
              res_next   = RES_PRESENT;
              state_next = S_FINISH;
            end
            CMD_LOOKUP: begin
              res_next   = RES_HIT;
              state_next = S_FINISH;
            end
            CMD_DELETE: state_next = S_DEL1;
            default: begin
              res_next   = RES_MISS;
              state_next = S_FINISH;
            end
          endcase
        end else if (sts.link_vld) begin
          state_next = S_WALK;
        end else if (sts.cmd == CMD_INSERT) begin
          state_next = S_SCAN_RD;
        end else begin
          res_next   = RES_MISS;
          state_next = S_FINISH;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CK;
      S_SCAN_CK: begin
        if (!sts.used) begin
          state_next = S_INS1;
        end else if (sts.scan_last) begin
          res_next   = RES_FULL;
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_INS1:    state_next = S_INS2;
      S_INS2: begin
        res_next   = RES_NEW;
        state_next = S_FINISH;
      end
      S_DEL1:    state_next = S_DEL2;
      S_DEL2: begin
        res_next   = RES_HIT;
        state_next = S_FINISH;
      end
      S_FINISH:  if (sts.out_free) state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl.op   = OP_NONE;
    ctl.res  = res;
    case (state)
      S_CLEAR:   ctl.op = OP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.op = OP_LOAD;
      end
      S_HASH:    ctl.op = OP_HASH;
      S_BKT:     ctl.op = OP_BKT;
      S_HRD:     ctl.op = OP_HEAD_RD;
      S_HCHK:    ctl.op = OP_HEAD_CHK;
      S_WALK:    ctl.op = OP_WALK;
      S_SCAN_RD: ctl.op = OP_SCAN_RD;
      S_SCAN_CK: ctl.op = OP_SCAN_CK;
      S_INS1:    ctl.op = OP_INS_SLOT;
      S_INS2:    ctl.op = OP_INS_LINK;
      S_DEL1:    ctl.op = OP_DEL_LINK;
      S_DEL2:    ctl.op = OP_DEL_SLOT;
      S_FINISH:  if (sts.out_free) ctl.op = OP_FINISH;
      default:   ctl.op = OP_NONE;
    endcase
  end

endmodule

FILE: sv/chained_hash_address_set.sv
// Top level of the chained hash address set.
// Set of {prefix, address} keys in a hash table with separate chaining over a
// pool of SLOTS slots. After reset the block clears its bucket, link and used
// memories, stepping a counter through max(BUCKETS, SLOTS) entries (1024), and
// accepts no transaction until done. Each request then hashes the key, reads
// the bucket head and walks the chain one entry at a time through the single
// read port of the slot memories; an insert of a new key then runs a free scan
// that probes slots one by one (used memory read then check) followed by the
// slot write and link update, a delete the unlink and slot clear. The result is
// held in an output register, and the next request is accepted while it waits.
module chained_hash_address_set import chas_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ctl_cmd_t   ctl;
  dp_status_t sts;

  chas_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  chas_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
